/* rtl/fspa_pkg.sv */
// Shared types, codes and constants for the fixed slot pool allocator.
package fspa_pkg;

    // Default pool size and fixed field widths
    localparam int SLOT_COUNT_DEF = 1024;
    localparam int SLOT_W         = 10;
    localparam int SLOT_MAX       = 1024;
    localparam int SIZE_W         = 13;
    localparam int BASE_W         = 32;
    localparam int LIMIT_W        = 11;
    localparam int ADDR_W         = 33;
    localparam int LINK_W         = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int PROD_W         = SLOT_W + SIZE_W;

    // Request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd2;

    // Configuration reset values
    localparam logic [SIZE_W-1:0]  SLOT_SIZE_RST    = 13'd8;
    localparam logic [BASE_W-1:0]  BASE_ADDRESS_RST = 32'd0;
    localparam logic [LIMIT_W-1:0] SLOTS_IN_USE_RST = 11'd1024;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_OOM  = 2'd1,
        STATUS_NULL = 2'd2
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // take the request word on the input ports
        logic finish;   // complete the request and load the result word
    } cmd_t;

endpackage

/* rtl/fixed_slot_pool_allocator.sv */
// Fixed slot pool allocator: each request passes through an accept step and
// a finish step, because a pop reads the next free-list link from the
// registered-read link memory before the new head is known; the finish step
// waits while an earlier result word is still held on the output, and a new
// request is not taken until the current one has finished. An allocate pops
// the most recently freed slot, otherwise takes the next never-used slot up
// to the smaller of slots_in_use and the pool size, otherwise answers out of
// memory. The link memory needs no clearing after reset. Configuration
// registers must be written only while no request is in flight; the block
// itself does not enforce this.
module fixed_slot_pool_allocator
    import fspa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [SLOT_W-1:0]     s_slot_number,
    input  logic                  s_null_mark,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [SLOT_W-1:0]     m_granted_slot,
    output logic [ADDR_W-1:0]     m_granted_address
);

    cmd_t cmd;

    fspa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fspa_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_action          (s_action),
        .s_slot_number     (s_slot_number),
        .s_null_mark       (s_null_mark),
        .m_status          (m_status),
        .m_granted_slot    (m_granted_slot),
        .m_granted_address (m_granted_address)
    );

    // Only a completed grant carries a slot or address
    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_DONE)) |->
            ((m_granted_slot == '0) && (m_granted_address == '0)))
        else $error("non-grant result word carries a slot or address");

endmodule

/* rtl/fspa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/fspa_ctrl.sv */
// Request sequencer: handshakes, two-state controller and result valid flag.
module fspa_ctrl
    import fspa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_FINISH = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Accept only in idle; finish once the result register is free
    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.accept = s_valid && s_ready;
    assign cmd.finish = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign m_valid    = m_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result word valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Each accepted word moves the controller to the finish state
    a_accept_to_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_FINISH))
        else $error("accepted word did not move the controller to finish");

    a_finish_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("finish did not present a result word");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept && cmd.finish))
        else $error("accept and finish in the same cycle");

endmodule

/* rtl/fspa_dp.sv */
// Allocator datapath: configuration, free-list head, bump index, link store
// and result word registers.
module fspa_dp
    import fspa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_action,
    input  logic [SLOT_W-1:0]     s_slot_number,
    input  logic                  s_null_mark,
    output logic [1:0]            m_status,
    output logic [SLOT_W-1:0]     m_granted_slot,
    output logic [ADDR_W-1:0]     m_granted_address
);

    localparam int LINK_DEPTH = (SLOT_COUNT < SLOT_MAX) ? SLOT_COUNT : SLOT_MAX;
    localparam int AW         = $clog2(LINK_DEPTH);
    localparam logic [16:0]        SLOT_LIMIT = 17'(SLOT_COUNT);
    localparam logic [LIMIT_W-1:0] BUMP_CAP   = LIMIT_W'(LINK_DEPTH);

    // Configuration registers
    logic [SIZE_W-1:0]  slot_size_reg;
    logic [BASE_W-1:0]  base_address_reg;
    logic [LIMIT_W-1:0] slots_in_use_reg;

    // Allocator state
    logic [SLOT_W-1:0]  free_head_reg, free_head_next;
    logic               nonempty_reg, nonempty_next;
    logic [LIMIT_W-1:0] bump_index_reg, bump_index_next;
    logic               pop_pending_reg, pop_pending_next;

    // Per-request work registers
    logic [SLOT_W-1:0]  granted_reg, granted_next;
    logic               grant_reg, grant_next;
    status_t            res_status_reg, res_status_next;
    logic [PROD_W-1:0]  prod_reg;

    // Result word
    status_t            m_status_reg;
    logic [SLOT_W-1:0]  m_granted_slot_reg;
    logic [ADDR_W-1:0]  m_granted_address_reg;

    // Link store port signals
    logic              link_wr_en;
    logic [LINK_W-1:0] link_wr_data;
    logic              link_rd_en;
    logic [LINK_W-1:0] link_rd_data;

    logic is_free;
    logic in_range;
    logic bump_ok;

    assign is_free  = (s_action == ACT_FREE);
    assign in_range = ({7'b0, s_slot_number} < SLOT_LIMIT);
    assign bump_ok  = (bump_index_reg < slots_in_use_reg) && (bump_index_reg < BUMP_CAP);

    assign link_wr_en   = cmd.accept && is_free && !s_null_mark && in_range;
    assign link_wr_data = {nonempty_reg, free_head_reg};
    assign link_rd_en   = cmd.accept && !is_free && nonempty_reg;

    fspa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (s_slot_number[AW-1:0]),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (free_head_reg[AW-1:0]),
        .rd_data (link_rd_data)
    );

    // Request decode: push, pop, bump, null or out of memory at accept; pop completion at finish
    always_comb begin
        free_head_next   = free_head_reg;
        nonempty_next    = nonempty_reg;
        bump_index_next  = bump_index_reg;
        pop_pending_next = pop_pending_reg;
        granted_next     = granted_reg;
        grant_next       = grant_reg;
        res_status_next  = res_status_reg;
        if (cmd.accept) begin
            granted_next     = '0;
            grant_next       = 1'b0;
            pop_pending_next = 1'b0;
            res_status_next  = STATUS_DONE;
            if (is_free) begin
                if (s_null_mark) begin
                    res_status_next = STATUS_NULL;
                end else if (in_range) begin
                    free_head_next = s_slot_number;
                    nonempty_next  = 1'b1;
                end
            end else if (nonempty_reg) begin
                granted_next     = free_head_reg;
                grant_next       = 1'b1;
                pop_pending_next = 1'b1;
            end else if (bump_ok) begin
                granted_next    = bump_index_reg[SLOT_W-1:0];
                grant_next      = 1'b1;
                bump_index_next = bump_index_reg + LIMIT_W'(1);
            end else begin
                res_status_next = STATUS_OOM;
            end
        end else if (cmd.finish && pop_pending_reg) begin
            // Link word read at accept is now on the RAM output
            free_head_next   = link_rd_data[SLOT_W-1:0];
            nonempty_next    = link_rd_data[LINK_W-1];
            pop_pending_next = 1'b0;
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_size_reg    <= SLOT_SIZE_RST;
            base_address_reg <= BASE_ADDRESS_RST;
            slots_in_use_reg <= SLOTS_IN_USE_RST;
            free_head_reg    <= '0;
            nonempty_reg     <= 1'b0;
            bump_index_reg   <= '0;
            pop_pending_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SLOT_SIZE:    slot_size_reg    <= cfg_wr_data[SIZE_W-1:0];
                    CFG_BASE_ADDRESS: base_address_reg <= cfg_wr_data[BASE_W-1:0];
                    CFG_SLOTS_IN_USE: slots_in_use_reg <= cfg_wr_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            free_head_reg   <= free_head_next;
            nonempty_reg    <= nonempty_next;
            bump_index_reg  <= bump_index_next;
            pop_pending_reg <= pop_pending_next;
        end
    end

    // Work registers; slot times size is taken at accept, base added at finish
    always_ff @(posedge aclk) begin
        granted_reg    <= granted_next;
        grant_reg      <= grant_next;
        res_status_reg <= res_status_next;
        if (cmd.accept) begin
            prod_reg <= {{SIZE_W{1'b0}}, granted_next} * {{SLOT_W{1'b0}}, slot_size_reg};
        end
        if (cmd.finish) begin
            m_status_reg       <= res_status_reg;
            m_granted_slot_reg <= granted_reg;
            if (grant_reg) begin
                m_granted_address_reg <= {1'b0, base_address_reg}
                                       + {{(ADDR_W-PROD_W){1'b0}}, prod_reg};
            end else begin
                m_granted_address_reg <= '0;
            end
        end
    end

    assign m_status          = m_status_reg;
    assign m_granted_slot    = m_granted_slot_reg;
    assign m_granted_address = m_granted_address_reg;

endmodule

/* test/fixed_slot_pool_allocator_tb.sv */
// Self-checking testbench for the fixed slot pool allocator: directed table, then random phases.
module fixed_slot_pool_allocator_tb;
    import fspa_pkg::*;

    localparam int  CYCLE_LIMIT = 300000;
    localparam int  LONG_HOLD   = 120;
    localparam int  HOLD_AFTER  = 220;     // words seen before the long receiver hold
    localparam int  QUIET_GAP   = 4;       // cycles left after the last word before a write
    localparam bit  ROW_WORD    = 1'b0;
    localparam bit  ROW_REG     = 1'b1;
    localparam bit  PINNED      = 1'b1;
    localparam bit  PREDICTED   = 1'b0;

    // One result word
    typedef struct packed {
        status_t           st;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
    } pool_result_t;

    // One row of the directed table: either a request word or a register write
    typedef struct packed {
        bit                   is_reg;
        logic                 act;
        logic                 nm;
        logic [SLOT_W-1:0]    slot;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_val;
        bit                   pinned;
        status_t              st;
        logic [SLOT_W-1:0]    g_slot;
        logic [ADDR_W-1:0]    g_addr;
    } plan_row_t;

    // Opening rows, from reset with default registers
    localparam plan_row_t OPENING [30] = '{
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0, 33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd1, 33'h8},
        '{ROW_WORD, ACT_FREE, 1'b1, 10'd1023, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_NULL, 10'd0, 33'h0},
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0, 33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b1, 10'd1023, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0, 33'h0},
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd1023, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0, 33'h0},
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd1, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0, 33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd1, 33'h8},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd1023,
          33'd8184},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd2, 33'd16},
        '{ROW_REG, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'd4096, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_REG, ACT_ALLOC, 1'b0, 10'd0, CFG_BASE_ADDRESS, 32'hFFFF_FFFF, PREDICTED, STATUS_DONE,
          10'd0, 33'h0},
        '{ROW_REG, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOTS_IN_USE, 32'd2047, PREDICTED, STATUS_DONE,
          10'd0, 33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd3,
          33'h1_0000_2FFF},
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd3, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0, 33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd3,
          33'h1_0000_2FFF},
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd1023, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd1023,
          33'h1_003F_EFFF},
        '{ROW_REG, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'd0, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_REG, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOTS_IN_USE, 32'd0, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_REG, ACT_ALLOC, 1'b0, 10'd0, CFG_BASE_ADDRESS, 32'h8000_0001, PREDICTED, STATUS_DONE,
          10'd0, 33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_OOM, 10'd0, 33'h0},
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd512, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0, 33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd512,
          33'h0_8000_0001},
        '{ROW_REG, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOTS_IN_USE, 32'd1, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_OOM, 10'd0, 33'h0},
        '{ROW_REG, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'd8191, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd682, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_DONE, 10'd0, 33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_WORD, ACT_FREE, 1'b1, 10'd341, CFG_SLOT_SIZE, 32'h0, PINNED, STATUS_NULL, 10'd0, 33'h0}
    };

    // Double free last of all: it loops the free list for good
    localparam plan_row_t CLOSING [4] = '{
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd1000, CFG_SLOT_SIZE, 32'h0, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_WORD, ACT_FREE, 1'b0, 10'd1000, CFG_SLOT_SIZE, 32'h0, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PREDICTED, STATUS_DONE, 10'd0,
          33'h0},
        '{ROW_WORD, ACT_ALLOC, 1'b0, 10'd0, CFG_SLOT_SIZE, 32'h0, PREDICTED, STATUS_DONE, 10'd0,
          33'h0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_action;
    logic [SLOT_W-1:0]     s_slot_number;
    logic                  s_null_mark;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_status;
    logic [SLOT_W-1:0]     m_granted_slot;
    logic [ADDR_W-1:0]     m_granted_address;

    // Predictor state, starting at the reset values
    logic [SIZE_W-1:0]  reg_slot_size = SLOT_SIZE_RST;
    logic [BASE_W-1:0]  reg_base      = BASE_ADDRESS_RST;
    logic [LIMIT_W-1:0] reg_slots     = SLOTS_IN_USE_RST;
    logic [SLOT_W-1:0]  list_head     = '0;
    logic               list_live     = 1'b0;
    logic [LIMIT_W-1:0] next_fresh    = '0;
    logic [LINK_W-1:0]  link_mem [SLOT_COUNT_DEF];
    bit                 on_list  [SLOT_COUNT_DEF];
    logic [SLOT_W-1:0]  held_slots [$];

    pool_result_t awaited_words [$];
    pool_result_t pin_want;
    bit           pin_typed;

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  words_out   = 0;
    int  sink_hold   = 0;
    bit  long_done   = 1'b0;
    bit  calm        = 1'b0;
    bit  send_gaps   = 1'b1;

    fixed_slot_pool_allocator DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_slot_number     (s_slot_number),
        .s_null_mark       (s_null_mark),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_slot    (m_granted_slot),
        .m_granted_address (m_granted_address)
    );

    // Clock, period 2
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Works out the result word of one request and moves the pool state on
    task automatic serve_request(input logic act, input logic [SLOT_W-1:0] slot,
                                 input logic nm, output pool_result_t res);
        logic [LINK_W-1:0]  link;
        logic [SLOT_W-1:0]  grant;
        logic [LIMIT_W-1:0] cap;
        res  = '{STATUS_DONE, '0, '0};
        cap  = (reg_slots > LIMIT_W'(SLOT_COUNT_DEF)) ? LIMIT_W'(SLOT_COUNT_DEF) : reg_slots;
        if (act == ACT_FREE) begin
            if (nm) begin
                res.st = STATUS_NULL;
            end else begin
                // 10-bit slot is always inside the pool; push onto the list
                link_mem[slot] = {list_live, list_head};
                list_head      = slot;
                list_live      = 1'b1;
                on_list[slot]  = 1'b1;
                for (int k = 0; k < held_slots.size(); k++) begin
                    if (held_slots[k] == slot) begin
                        held_slots.delete(k);
                        break;
                    end
                end
            end
        end else begin
            if (list_live) begin
                grant          = list_head;
                link           = link_mem[grant];
                list_head      = link[SLOT_W-1:0];
                list_live      = link[SLOT_W];
                on_list[grant] = 1'b0;
            end else if (next_fresh < cap) begin
                grant      = next_fresh[SLOT_W-1:0];
                next_fresh = next_fresh + LIMIT_W'(1);
            end else begin
                res.st = STATUS_OOM;
                return;
            end
            res.slot = grant;
            res.addr = ADDR_W'(reg_base) + ADDR_W'(grant) * ADDR_W'(reg_slot_size);
            held_slots.push_back(grant);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0d: %s mismatch, expected %0h, got %0h", cycle_count, what, want, got);
    endtask

    // Scoreboard: register writes, accepted requests and result words
    always @(posedge aclk) begin : scoreboard
        pool_result_t res;
        pool_result_t want;
        cycle_count++;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SLOT_SIZE:    reg_slot_size = cfg_wr_data[SIZE_W-1:0];
                    CFG_BASE_ADDRESS: reg_base      = cfg_wr_data[BASE_W-1:0];
                    CFG_SLOTS_IN_USE: reg_slots     = cfg_wr_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                serve_request(s_action, s_slot_number, s_null_mark, res);
                if (pin_typed)
                    res = pin_want;
                awaited_words.push_back(res);
            end
            if (m_valid && m_ready) begin
                words_out++;
                if (awaited_words.size() == 0) begin
                    note_mismatch("unexpected word, status", '0, 64'(m_status));
                end else begin
                    want = awaited_words.pop_front();
                    if (m_status !== want.st)
                        note_mismatch("status", 64'(want.st), 64'(m_status));
                    if (m_granted_slot !== want.slot)
                        note_mismatch("granted_slot", 64'(want.slot), 64'(m_granted_slot));
                    if (m_granted_address !== want.addr)
                        note_mismatch("granted_address", 64'(want.addr),
                                      64'(m_granted_address));
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: short random stalls, one long hold, none in the calm tail
    always @(negedge aclk) begin
        if (!long_done && words_out >= HOLD_AFTER) begin
            long_done = 1'b1;
            sink_hold = LONG_HOLD;
        end else if (sink_hold == 0 && !calm && (cycle_count / 128) % 3 != 0
                     && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(1, 10);
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offers one request word; called at a falling edge, returns at the next
    // falling edge after acceptance with valid still high
    task automatic offer(input logic act, input logic [SLOT_W-1:0] slot, input logic nm,
                         input bit typed, input pool_result_t want);
        pin_typed = typed;
        pin_want  = want;
        s_valid       <= 1'b1;
        s_action      <= act;
        s_slot_number <= slot;
        s_null_mark   <= nm;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic pause(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Sender waits until every awaited word has come and the block is quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_words.size() != 0) @(negedge aclk);
        repeat (QUIET_GAP) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic walk_row(input plan_row_t row);
        if (row.is_reg) begin
            settle();
            write_reg(row.reg_idx, row.reg_val);
        end else begin
            offer(row.act, row.slot, row.nm, row.pinned, '{row.st, row.g_slot, row.g_addr});
        end
    endtask

    // Mostly alloc and well-formed frees of held slots, some null and stray frees
    task automatic random_words(input int count);
        int                pick;
        logic [SLOT_W-1:0] slot;
        for (int n = 0; n < count; n++) begin
            if (n % 30 == 0)
                send_gaps = $urandom_range(0, 2) != 0;
            if (!calm && send_gaps && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 10));
            pick = $urandom_range(0, 99);
            if (pick < 45 || (pick < 85 && held_slots.size() == 0)) begin
                offer(ACT_ALLOC, SLOT_W'($urandom), 1'($urandom), PREDICTED, '0);
            end else if (pick < 85) begin
                slot = held_slots[$urandom_range(0, held_slots.size() - 1)];
                offer(ACT_FREE, slot, 1'b0, PREDICTED, '0);
            end else if (pick < 92) begin
                offer(ACT_FREE, SLOT_W'($urandom), 1'b1, PREDICTED, '0);
            end else begin
                // stray free of a slot the bump source never reaches; never one on the list
                slot = SLOT_W'($urandom_range(900, SLOT_COUNT_DEF - 1));
                offer(ACT_FREE, slot, on_list[slot], PREDICTED, '0);
            end
        end
    endtask

    // Reset, directed table, random phases, closing rows, drain
    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_SLOT_SIZE;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_action      = ACT_ALLOC;
        s_slot_number = '0;
        s_null_mark   = 1'b0;
        m_ready       = 1'b0;
        pin_typed     = PREDICTED;
        pin_want      = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (OPENING[i])
            walk_row(OPENING[i]);

        // full pool, random base
        settle();
        write_reg(CFG_SLOT_SIZE, $urandom_range(8, 4096));
        write_reg(CFG_BASE_ADDRESS, $urandom);
        write_reg(CFG_SLOTS_IN_USE, SLOT_COUNT_DEF);
        random_words(140);

        // bump source off, zero slot size
        settle();
        write_reg(CFG_SLOT_SIZE, 0);
        write_reg(CFG_BASE_ADDRESS, $urandom);
        write_reg(CFG_SLOTS_IN_USE, 0);
        random_words(100);

        // bump limit just ahead of the bump index, widest size and base
        settle();
        write_reg(CFG_SLOT_SIZE, 8191);
        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_SLOTS_IN_USE,
                  (int'(next_fresh) + 6 > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : int'(next_fresh) + 6);
        random_words(130);

        // limit above the pool size; second half without any idling
        settle();
        write_reg(CFG_SLOT_SIZE, $urandom_range(8, 4096));
        write_reg(CFG_BASE_ADDRESS, 0);
        write_reg(CFG_SLOTS_IN_USE, 2047);
        random_words(80);
        settle();
        @(posedge aclk);
        calm = 1'b1;
        @(negedge aclk);
        random_words(80);

        foreach (CLOSING[i])
            walk_row(CLOSING[i]);
        s_valid <= 1'b0;

        while (awaited_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
